[rtl/compton_scatter_angle_check_defines.svh]
// Assertion macros used by the top RTL file of the scatter angle check.
// Each macro expects signals named clk and rst_n in the scope of use.
`ifndef COMPTON_SCATTER_ANGLE_CHECK_DEFINES_SVH
`define COMPTON_SCATTER_ANGLE_CHECK_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define CSAC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csac assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CSAC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csac assertion failed");

`else

`define CSAC_ASSERT_SAME(label, ante, cons)
`define CSAC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[rtl/csac_pkg.sv]
// Widths, constants and stage types of the scatter angle check.
package csac_pkg;

    // Field widths.
    localparam int COORD_BITS  = 20;
    localparam int ENERGY_BITS = 24;
    localparam int TOL_BITS    = 24;
    localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(10000);

    // Direction vectors; wide coordinates are shifted down to 30 bits of range.
    localparam int RED_SHIFT = (COORD_BITS > 30) ? (COORD_BITS - 30) : 0;
    localparam int DW_W      = COORD_BITS + 1;
    localparam int DIFF_W    = DW_W - RED_SHIFT;
    localparam int PSQ_W     = 2 * DIFF_W;
    localparam int NA_W      = 2 * DIFF_W + 1;
    localparam int DOT_W     = 2 * DIFF_W + 2;

    // Split multiplication of the two squared lengths.
    localparam int HALF_W = (NA_W + 1) / 2;
    localparam int HI_W   = NA_W - HALF_W;
    localparam int MID_W  = HALF_W + HI_W + 1;
    localparam int PROD_W = 2 * NA_W;

    // Square root of the product.
    localparam int SQ_W     = NA_W;
    localparam int SQ_REM_W = SQ_W + 1;
    localparam int SQ_TRY_W = SQ_W + 3;

    // Cosine in Q1.30 and u = 1 - cos.
    localparam int Q_FRAC = 30;
    localparam int QC_W   = 31;
    localparam int U_W    = 32;
    localparam logic [QC_W-1:0] ONE_Q = QC_W'(1) << Q_FRAC;
    localparam logic [U_W-1:0]  ONE_U = U_W'(1) << Q_FRAC;

    // Deposit division.
    localparam int MEC2_EV = 510999;
    localparam int MEC_W   = 49;
    localparam logic [MEC_W-1:0] MEC_Q30 = MEC_W'(MEC2_EV) << Q_FRAC;
    localparam int EE_W    = 2 * ENERGY_BITS;
    localparam int EEL_W   = (EE_W + 1) / 2;
    localparam int EEH_W   = EE_W - EEL_W;
    localparam int EU_W    = ENERGY_BITS + U_W;
    localparam int NUM_W   = EE_W + U_W;
    localparam int DEN_W   = ((EU_W > MEC_W) ? EU_W : MEC_W) + 1;
    localparam int GAP_W   = (ENERGY_BITS > TOL_BITS) ? ENERGY_BITS : TOL_BITS;

    // Per-item sideband that follows the data down the pipeline.
    typedef struct packed {
        logic                   deg;
        logic                   neg;
        logic [ENERGY_BITS-1:0] e;
        logic [ENERGY_BITS-1:0] meas;
    } side_t;

    // One step of the square root.
    typedef struct packed {
        logic              vld;
        side_t             side;
        logic [SQ_W-1:0]   mag;
        logic [PROD_W-1:0] rad;
        logic [SQ_REM_W-1:0] rem;
        logic [SQ_W-1:0]   root;
    } sq_step_t;

    // One step of the cosine division.
    typedef struct packed {
        logic            vld;
        side_t           side;
        logic [SQ_W-1:0] d;
        logic [SQ_W-1:0] rem;
        logic [QC_W-1:0] q;
    } cd_step_t;

    // One step of the deposit division.
    typedef struct packed {
        logic                   vld;
        logic                   deg;
        logic [ENERGY_BITS-1:0] meas;
        logic [DEN_W-1:0]       den;
        logic [DEN_W-1:0]       rem;
        logic [ENERGY_BITS-1:0] low;
        logic [ENERGY_BITS-1:0] q;
    } ed_step_t;

endpackage

[rtl/compton_scatter_angle_check.sv]
// Compton scatter angle check. Each input word holds three ordered hit positions,
// the measured deposit at the middle hit and the gamma energy arriving there; each
// output word gives the predicted deposit, a degenerate flag for a zero-length
// direction and an acceptable flag when the prediction lies strictly within the
// tolerance register of the measurement. The block is a single pipeline that
// takes one word every cycle while the output register is free or being taken;
// its depth is set by the bit-per-stage square root, the 31-stage cosine
// divider and the ENERGY_BITS-stage deposit divider. When the output register is
// full and not taken, the whole pipeline holds. The tolerance register is written
// through cfg_write and cfg_data and should only change while no word is in flight.
`include "compton_scatter_angle_check_defines.svh"

module compton_scatter_angle_check (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write,
    input  logic [csac_pkg::TOL_BITS-1:0]          cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [csac_pkg::COORD_BITS-1:0] first_x,
    input  logic signed [csac_pkg::COORD_BITS-1:0] first_y,
    input  logic signed [csac_pkg::COORD_BITS-1:0] first_z,
    input  logic signed [csac_pkg::COORD_BITS-1:0] second_x,
    input  logic signed [csac_pkg::COORD_BITS-1:0] second_y,
    input  logic signed [csac_pkg::COORD_BITS-1:0] second_z,
    input  logic signed [csac_pkg::COORD_BITS-1:0] third_x,
    input  logic signed [csac_pkg::COORD_BITS-1:0] third_y,
    input  logic signed [csac_pkg::COORD_BITS-1:0] third_z,
    input  logic [csac_pkg::ENERGY_BITS-1:0]       measured_deposit,
    input  logic [csac_pkg::ENERGY_BITS-1:0]       gamma_energy,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   acceptable,
    output logic [csac_pkg::ENERGY_BITS-1:0]       predicted_deposit,
    output logic                                   degenerate
);
    import csac_pkg::*;

    logic adv;

    logic [TOL_BITS-1:0] tol_reg;

    logic signed [COORD_BITS-1:0] pa [3];
    logic signed [COORD_BITS-1:0] pb [3];
    logic signed [COORD_BITS-1:0] pc [3];

    logic                     s1_vld_reg;
    side_t                    s1_side_reg;
    logic signed [DIFF_W-1:0] s1_a_reg [3];
    logic signed [DIFF_W-1:0] s1_b_reg [3];
    logic signed [DIFF_W-1:0] s1_a_next [3];
    logic signed [DIFF_W-1:0] s1_b_next [3];

    logic                    s2_vld_reg;
    side_t                   s2_side_reg;
    logic signed [PSQ_W-1:0] s2_aa_reg [3];
    logic signed [PSQ_W-1:0] s2_bb_reg [3];
    logic signed [PSQ_W-1:0] s2_ab_reg [3];

    logic                    s3_vld_reg;
    side_t                   s3_side_reg;
    logic [NA_W-1:0]         s3_na_reg;
    logic [NA_W-1:0]         s3_nb_reg;
    logic signed [DOT_W-1:0] s3_dot_reg;

    logic                    s4_vld_reg;
    side_t                   s4_side_reg;
    logic [SQ_W-1:0]         s4_mag_reg;
    logic [2*HALF_W-1:0]     s4_ll_reg;
    logic [HALF_W+HI_W-1:0]  s4_lh_reg;
    logic [HALF_W+HI_W-1:0]  s4_hl_reg;
    logic [2*HI_W-1:0]       s4_hh_reg;
    logic [DOT_W-1:0]        s4_neg_dot;

    sq_step_t s5_reg;
    sq_step_t s5_next;
    sq_step_t sq_in   [SQ_W];
    sq_step_t sq_next [SQ_W];
    sq_step_t sq_reg  [SQ_W];

    cd_step_t cd_in   [QC_W];
    cd_step_t cd_next [QC_W];
    cd_step_t cd_reg  [QC_W];

    logic            uu_vld_reg;
    side_t           uu_side_reg;
    logic [U_W-1:0]  uu_u_reg;
    logic [QC_W-1:0] uu_q_clamp;

    logic             m1_vld_reg;
    side_t            m1_side_reg;
    logic [EE_W-1:0]  m1_ee_reg;
    logic [EU_W-1:0]  m1_eu_reg;
    logic [U_W-1:0]   m1_u_reg;

    logic                   m2_vld_reg;
    side_t                  m2_side_reg;
    logic [EEH_W+U_W-1:0]   m2_ph_reg;
    logic [EEL_W+U_W-1:0]   m2_pl_reg;
    logic [DEN_W-1:0]       m2_den_reg;

    logic             m3_vld_reg;
    side_t            m3_side_reg;
    logic [NUM_W-1:0] m3_num_reg;
    logic [DEN_W-1:0] m3_den_reg;

    ed_step_t ed_in   [ENERGY_BITS];
    ed_step_t ed_next [ENERGY_BITS];
    ed_step_t ed_reg  [ENERGY_BITS];

    logic                   out_valid_reg;
    logic                   acceptable_reg;
    logic [ENERGY_BITS-1:0] predicted_reg;
    logic                   degenerate_reg;
    logic                   acceptable_next;
    logic [ENERGY_BITS-1:0] predicted_next;
    logic [GAP_W-1:0]       gap;

    // The whole pipeline moves whenever the output register is free or being taken.
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // Tolerance register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (cfg_write)
        begin
            tol_reg <= cfg_data;
        end
    end

    // Stage 1: direction vectors a = second - first and b = third - second.
    assign pa = '{first_x, first_y, first_z};
    assign pb = '{second_x, second_y, second_z};
    assign pc = '{third_x, third_y, third_z};

    always_comb
    begin
        logic signed [DW_W-1:0] da;
        logic signed [DW_W-1:0] db;
        for (int i = 0; i < 3; i++)
        begin
            da = (DW_W'(pb[i]) - DW_W'(pa[i])) >>> RED_SHIFT;
            db = (DW_W'(pc[i]) - DW_W'(pb[i])) >>> RED_SHIFT;
            s1_a_next[i] = da[DIFF_W-1:0];
            s1_b_next[i] = db[DIFF_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_side_reg <= '{deg: 1'b0, neg: 1'b0, e: gamma_energy,
                             meas: measured_deposit};
            s1_a_reg    <= s1_a_next;
            s1_b_reg    <= s1_b_next;
        end
    end

    // Stage 2: the nine component products.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_side_reg <= s1_side_reg;
            for (int i = 0; i < 3; i++)
            begin
                s2_aa_reg[i] <= s1_a_reg[i] * s1_a_reg[i];
                s2_bb_reg[i] <= s1_b_reg[i] * s1_b_reg[i];
                s2_ab_reg[i] <= s1_a_reg[i] * s1_b_reg[i];
            end
        end
    end

    // Stage 3: squared lengths and the dot product.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_side_reg <= s2_side_reg;
            s3_na_reg   <= NA_W'(s2_aa_reg[0]) + NA_W'(s2_aa_reg[1]) + NA_W'(s2_aa_reg[2]);
            s3_nb_reg   <= NA_W'(s2_bb_reg[0]) + NA_W'(s2_bb_reg[1]) + NA_W'(s2_bb_reg[2]);
            s3_dot_reg  <= DOT_W'(s2_ab_reg[0]) + DOT_W'(s2_ab_reg[1])
                           + DOT_W'(s2_ab_reg[2]);
        end
    end

    // Stage 4: partial products of na * nb, sign and magnitude of the dot product.
    assign s4_neg_dot = -s3_dot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_side_reg      <= '{deg: (s3_na_reg == '0) || (s3_nb_reg == '0),
                                  neg: s3_dot_reg[DOT_W-1],
                                  e: s3_side_reg.e, meas: s3_side_reg.meas};
            s4_mag_reg       <= s3_dot_reg[DOT_W-1] ? s4_neg_dot[SQ_W-1:0]
                                                    : s3_dot_reg[SQ_W-1:0];
            s4_ll_reg <= s3_na_reg[HALF_W-1:0] * s3_nb_reg[HALF_W-1:0];
            s4_lh_reg <= s3_na_reg[HALF_W-1:0] * s3_nb_reg[NA_W-1:HALF_W];
            s4_hl_reg <= s3_na_reg[NA_W-1:HALF_W] * s3_nb_reg[HALF_W-1:0];
            s4_hh_reg <= s3_na_reg[NA_W-1:HALF_W] * s3_nb_reg[NA_W-1:HALF_W];
        end
    end

    // Stage 5: assemble the full product, the radicand of the square root.
    always_comb
    begin
        s5_next      = '0;
        s5_next.vld  = s4_vld_reg;
        s5_next.side = s4_side_reg;
        s5_next.mag  = s4_mag_reg;
        s5_next.rad  = (PROD_W'(s4_hh_reg) << (2 * HALF_W))
                       + (PROD_W'(MID_W'(s4_lh_reg) + MID_W'(s4_hl_reg)) << HALF_W)
                       + PROD_W'(s4_ll_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_reg <= '0;
        end
        else if (adv)
        begin
            s5_reg <= s5_next;
        end
    end

    // Square root, one result bit per stage.
    always_comb
    begin
        logic [SQ_TRY_W-1:0] rem2;
        logic [SQ_TRY_W-1:0] trial;
        sq_in[0] = s5_reg;
        for (int k = 1; k < SQ_W; k++)
        begin
            sq_in[k] = sq_reg[k-1];
        end
        for (int k = 0; k < SQ_W; k++)
        begin
            rem2           = {sq_in[k].rem, sq_in[k].rad[PROD_W-1 -: 2]};
            trial          = {1'b0, sq_in[k].root, 2'b01};
            sq_next[k]     = sq_in[k];
            sq_next[k].rad = sq_in[k].rad << 2;
            if (rem2 >= trial)
            begin
                sq_next[k].rem  = SQ_REM_W'(rem2 - trial);
                sq_next[k].root = {sq_in[k].root[SQ_W-2:0], 1'b1};
            end
            else
            begin
                sq_next[k].rem  = rem2[SQ_REM_W-1:0];
                sq_next[k].root = {sq_in[k].root[SQ_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SQ_W; k++)
            begin
                sq_reg[k] <= '0;
            end
        end
        else if (adv)
        begin
            sq_reg <= sq_next;
        end
    end

    // Cosine magnitude |dot| * 2^30 / s, one quotient bit per stage.
    always_comb
    begin
        logic [SQ_W:0] rem2;
        logic          feed;
        cd_in[0].vld  = sq_reg[SQ_W-1].vld;
        cd_in[0].side = sq_reg[SQ_W-1].side;
        cd_in[0].d    = sq_reg[SQ_W-1].root;
        cd_in[0].rem  = {1'b0, sq_reg[SQ_W-1].mag[SQ_W-1:1]};
        cd_in[0].q    = '0;
        for (int k = 1; k < QC_W; k++)
        begin
            cd_in[k] = cd_reg[k-1];
        end
        for (int k = 0; k < QC_W; k++)
        begin
            feed       = (k == 0) ? sq_reg[SQ_W-1].mag[0] : 1'b0;
            rem2       = {cd_in[k].rem, feed};
            cd_next[k] = cd_in[k];
            if (rem2 >= {1'b0, cd_in[k].d})
            begin
                cd_next[k].rem = SQ_W'(rem2 - {1'b0, cd_in[k].d});
                cd_next[k].q   = {cd_in[k].q[QC_W-2:0], 1'b1};
            end
            else
            begin
                cd_next[k].rem = rem2[SQ_W-1:0];
                cd_next[k].q   = {cd_in[k].q[QC_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < QC_W; k++)
            begin
                cd_reg[k] <= '0;
            end
        end
        else if (adv)
        begin
            cd_reg <= cd_next;
        end
    end

    // Clamp the cosine and form u = 1 - cos.
    assign uu_q_clamp = (cd_reg[QC_W-1].q > ONE_Q) ? ONE_Q : cd_reg[QC_W-1].q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uu_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            uu_vld_reg <= cd_reg[QC_W-1].vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            uu_side_reg <= cd_reg[QC_W-1].side;
            uu_u_reg    <= cd_reg[QC_W-1].side.neg ? ONE_U + U_W'(uu_q_clamp)
                                                   : ONE_U - U_W'(uu_q_clamp);
        end
    end

    // E * E and E * u.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            m1_vld_reg <= uu_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_side_reg <= uu_side_reg;
            m1_u_reg    <= uu_u_reg;
            m1_ee_reg   <= EE_W'(uu_side_reg.e) * EE_W'(uu_side_reg.e);
            m1_eu_reg   <= EU_W'(uu_side_reg.e) * EU_W'(uu_u_reg);
        end
    end

    // Halves of E * E * u, and the denominator mec2 * 2^30 + E * u.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            m2_vld_reg <= m1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m2_side_reg <= m1_side_reg;
            m2_ph_reg   <= (EEH_W + U_W)'(m1_ee_reg[EE_W-1:EEL_W]) * (EEH_W + U_W)'(m1_u_reg);
            m2_pl_reg   <= (EEL_W + U_W)'(m1_ee_reg[EEL_W-1:0]) * (EEL_W + U_W)'(m1_u_reg);
            m2_den_reg  <= DEN_W'(MEC_Q30) + DEN_W'(m1_eu_reg);
        end
    end

    // Full numerator.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m3_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            m3_vld_reg <= m2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m3_side_reg <= m2_side_reg;
            m3_num_reg  <= (NUM_W'(m2_ph_reg) << EEL_W) + NUM_W'(m2_pl_reg);
            m3_den_reg  <= m2_den_reg;
        end
    end

    // Deposit division, one quotient bit per stage.
    always_comb
    begin
        logic [DEN_W:0] rem2;
        ed_in[0].vld  = m3_vld_reg;
        ed_in[0].deg  = m3_side_reg.deg;
        ed_in[0].meas = m3_side_reg.meas;
        ed_in[0].den  = m3_den_reg;
        ed_in[0].rem  = DEN_W'(m3_num_reg[NUM_W-1:ENERGY_BITS]);
        ed_in[0].low  = m3_num_reg[ENERGY_BITS-1:0];
        ed_in[0].q    = '0;
        for (int k = 1; k < ENERGY_BITS; k++)
        begin
            ed_in[k] = ed_reg[k-1];
        end
        for (int k = 0; k < ENERGY_BITS; k++)
        begin
            rem2           = {ed_in[k].rem, ed_in[k].low[ENERGY_BITS-1]};
            ed_next[k]     = ed_in[k];
            ed_next[k].low = ed_in[k].low << 1;
            if (rem2 >= {1'b0, ed_in[k].den})
            begin
                ed_next[k].rem = DEN_W'(rem2 - {1'b0, ed_in[k].den});
                ed_next[k].q   = {ed_in[k].q[ENERGY_BITS-2:0], 1'b1};
            end
            else
            begin
                ed_next[k].rem = rem2[DEN_W-1:0];
                ed_next[k].q   = {ed_in[k].q[ENERGY_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ENERGY_BITS; k++)
            begin
                ed_reg[k] <= '0;
            end
        end
        else if (adv)
        begin
            ed_reg <= ed_next;
        end
    end

    // Tolerance test and the output register.
    always_comb
    begin
        if (ed_reg[ENERGY_BITS-1].q >= ed_reg[ENERGY_BITS-1].meas)
        begin
            gap = GAP_W'(ed_reg[ENERGY_BITS-1].q - ed_reg[ENERGY_BITS-1].meas);
        end
        else
        begin
            gap = GAP_W'(ed_reg[ENERGY_BITS-1].meas - ed_reg[ENERGY_BITS-1].q);
        end
        if (ed_reg[ENERGY_BITS-1].deg)
        begin
            predicted_next  = '0;
            acceptable_next = 1'b0;
        end
        else
        begin
            predicted_next  = ed_reg[ENERGY_BITS-1].q;
            acceptable_next = gap < GAP_W'(tol_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= ed_reg[ENERGY_BITS-1].vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            acceptable_reg <= acceptable_next;
            predicted_reg  <= predicted_next;
            degenerate_reg <= ed_reg[ENERGY_BITS-1].deg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign acceptable        = acceptable_reg;
    assign predicted_deposit = predicted_reg;
    assign degenerate        = degenerate_reg;

    // A degenerate word carries no prediction and is never acceptable.
    `CSAC_ASSERT_SAME(a_deg_clean, out_valid_reg && degenerate_reg,
        !acceptable_reg && (predicted_reg == '0))
    // By Cauchy-Schwarz the cosine quotient never exceeds one.
    `CSAC_ASSERT_SAME(a_cos_range, cd_reg[QC_W-1].vld && !cd_reg[QC_W-1].side.deg,
        cd_reg[QC_W-1].q <= ONE_Q)
    // The deposit quotient fits the energy width, so the first remainder is below the divisor.
    `CSAC_ASSERT_SAME(a_dep_fits, m3_vld_reg && !m3_side_reg.deg,
        ed_in[0].rem < ed_in[0].den)
    // With a zero tolerance nothing passes.
    `CSAC_ASSERT_NEXT(a_zero_tol, adv && (tol_reg == '0) && !cfg_write,
        !acceptable_reg)

endmodule

[tb/tb_compton_scatter_angle_check.sv]
module tb_compton_scatter_angle_check;
    import csac_pkg::*;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [ENERGY_BITS-1:0] energy_t;

    // One input word: three hits and two energies.
    typedef struct {
        coord_t  p [9];
        energy_t meas;
        energy_t e;
    } hit_t;

    // One output word.
    typedef struct {
        logic    acc;
        energy_t pred;
        logic    deg;
    } verdict_t;

    // A row of the directed table, with a typed expectation where one is obvious.
    typedef struct {
        hit_t     h;
        logic     typed;
        verdict_t v;
    } row_t;

    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 150;
    localparam int N_DIRECTED = 12;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [TOL_BITS-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    coord_t first_x, first_y, first_z;
    coord_t second_x, second_y, second_z;
    coord_t third_x, third_y, third_z;
    energy_t measured_deposit;
    energy_t gamma_energy;
    logic out_valid;
    logic out_ready;
    logic acceptable;
    energy_t predicted_deposit;
    logic degenerate;

    verdict_t pending_q [$];
    logic [TOL_BITS-1:0] tol_copy;
    hit_t cur_hit;
    logic cur_typed;
    verdict_t cur_verdict;
    int words_sent;
    int words_seen;
    int fail_count;
    logic any_fire;
    row_t rows [N_DIRECTED];

    compton_scatter_angle_check u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .first_x           (first_x),
        .first_y           (first_y),
        .first_z           (first_z),
        .second_x          (second_x),
        .second_y          (second_y),
        .second_z          (second_z),
        .third_x           (third_x),
        .third_y           (third_y),
        .third_z           (third_z),
        .measured_deposit  (measured_deposit),
        .gamma_energy      (gamma_energy),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .acceptable        (acceptable),
        .predicted_deposit (predicted_deposit),
        .degenerate        (degenerate)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Compton deposit prediction from the scattering geometry.
    function automatic verdict_t compton_deposit(hit_t h, logic [TOL_BITS-1:0] tol);
        verdict_t r;
        longint a [3];
        longint b [3];
        longint na;
        longint nb;
        longint dot;
        logic [127:0] prod;
        logic [127:0] root;
        logic [127:0] cand;
        logic [127:0] mag;
        logic [127:0] q;
        longint cosv;
        logic [127:0] u;
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] pred;
        logic [127:0] gap;
        na = 0;
        nb = 0;
        dot = 0;
        for (int i = 0; i < 3; i++)
        begin
            a[i] = longint'(h.p[3+i]) - longint'(h.p[i]);
            b[i] = longint'(h.p[6+i]) - longint'(h.p[3+i]);
            na += a[i] * a[i];
            nb += b[i] * b[i];
            dot += a[i] * b[i];
        end
        r.acc = 1'b0;
        r.pred = '0;
        r.deg = 1'b0;
        if (na == 0 || nb == 0)
        begin
            r.deg = 1'b1;
            return r;
        end
        // Integer square root of the product of the squared lengths.
        prod = 128'(na) * 128'(nb);
        root = '0;
        for (int k = 62; k >= 0; k--)
        begin
            cand = root | (128'(1) << k);
            if (cand * cand <= prod)
                root = cand;
        end
        mag = (dot < 0) ? 128'(-dot) : 128'(dot);
        q = (mag << 30) / root;
        if (q > (128'(1) << 30))
            q = 128'(1) << 30;
        cosv = (dot < 0) ? -longint'(q) : longint'(q);
        u = 128'((longint'(1) << 30) - cosv);
        num = 128'(h.e) * 128'(h.e) * u;
        den = (128'(MEC2_EV) << 30) + 128'(h.e) * u;
        pred = num / den;
        gap = (pred >= 128'(h.meas)) ? pred - 128'(h.meas) : 128'(h.meas) - pred;
        r.acc = (gap < 128'(tol));
        r.pred = pred[ENERGY_BITS-1:0];
        return r;
    endfunction

    function automatic hit_t make_hit(int fx, int fy, int fz, int sx, int sy, int sz,
                                      int tx, int ty, int tz, int meas, int e);
        hit_t h;
        h.p[0] = coord_t'(fx);
        h.p[1] = coord_t'(fy);
        h.p[2] = coord_t'(fz);
        h.p[3] = coord_t'(sx);
        h.p[4] = coord_t'(sy);
        h.p[5] = coord_t'(sz);
        h.p[6] = coord_t'(tx);
        h.p[7] = coord_t'(ty);
        h.p[8] = coord_t'(tz);
        h.meas = energy_t'(meas);
        h.e = energy_t'(e);
        return h;
    endfunction

    // Random event: mostly sound geometry, some degenerate, some close to the prediction.
    function automatic hit_t random_hit();
        hit_t h;
        int kind;
        int base;
        longint m;
        verdict_t v;
        kind = $urandom_range(9);
        for (int i = 0; i < 9; i++)
        begin
            if (kind == 2 || kind == 3)
            begin
                base = $urandom_range(100000) - 50000;
                h.p[i] = coord_t'(base + $urandom_range(2000) - 1000);
            end
            else
                h.p[i] = coord_t'($urandom);
        end
        if (kind == 0)
            for (int i = 0; i < 3; i++)
                h.p[3+i] = h.p[i];
        if (kind == 1)
            for (int i = 0; i < 3; i++)
                h.p[6+i] = h.p[3+i];
        h.e = ($urandom_range(3) == 0) ? energy_t'($urandom) : energy_t'($urandom_range(3000000));
        h.meas = energy_t'($urandom);
        if ($urandom_range(1) == 1)
        begin
            v = compton_deposit(h, '0);
            m = longint'(v.pred) + $urandom_range(40000) - 20000;
            if (m < 0)
                m = 0;
            if (m > 16777215)
                m = 16777215;
            h.meas = energy_t'(m);
        end
        return h;
    endfunction

    // Offer one word and hold it until it is taken.
    task automatic send_word(hit_t h, logic typed, verdict_t v);
        logic taken;
        cur_hit = h;
        cur_typed = typed;
        cur_verdict = v;
        first_x <= h.p[0];
        first_y <= h.p[1];
        first_z <= h.p[2];
        second_x <= h.p[3];
        second_y <= h.p[4];
        second_z <= h.p[5];
        third_x <= h.p[6];
        third_y <= h.p[7];
        third_z <= h.p[8];
        measured_deposit <= h.meas;
        gamma_energy <= h.e;
        in_valid <= 1'b1;
        do
        begin
            @(negedge clk);
            taken = in_valid && in_ready;
            @(posedge clk);
        end
        while (!taken);
        words_sent++;
    endtask

    // Idle gaps on the input side, none inside the calm window.
    task automatic maybe_idle();
        while (!(words_sent >= 300 && words_sent < 380) && $urandom_range(99) < 27)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Tolerance writes only once the pipeline has drained.
    task automatic write_tolerance(logic [TOL_BITS-1:0] value);
        in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        tol_copy = value;
    endtask

    task automatic random_phase(int n);
        verdict_t none;
        none = '{1'b0, '0, 1'b0};
        for (int i = 0; i < n; i++)
        begin
            maybe_idle();
            send_word(random_hit(), 1'b0, none);
        end
    endtask

    // Stimulus.
    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        {first_x, first_y, first_z} = '0;
        {second_x, second_y, second_z} = '0;
        {third_x, third_y, third_z} = '0;
        measured_deposit = '0;
        gamma_energy = '0;
        tol_copy = TOL_RESET;
        cur_typed = 1'b0;
        words_sent = 0;

        rows[0] = '{make_hit(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, '{1'b0, '0, 1'b1}};
        rows[1] = '{make_hit(5, -7, 9, 5, -7, 9, 100, 0, 3, 16777215, 16777215), 1'b1,
                    '{1'b0, '0, 1'b1}};
        rows[2] = '{make_hit(-524288, 0, 1, 524287, 2, 3, 524287, 2, 3, 100, 200000), 1'b1,
                    '{1'b0, '0, 1'b1}};
        rows[3] = '{make_hit(0, 0, 0, 100, 0, 0, 300, 0, 0, 0, 1000000), 1'b1,
                    '{1'b1, '0, 1'b0}};
        rows[4] = '{make_hit(0, 0, 0, 100, 0, 0, 300, 0, 0, 10000, 1000000), 1'b1,
                    '{1'b0, '0, 1'b0}};
        rows[5] = '{make_hit(0, 0, 0, 100, 0, 0, 300, 0, 0, 9999, 1000000), 1'b1,
                    '{1'b1, '0, 1'b0}};
        rows[6] = '{make_hit(0, 0, 0, 100, 0, 0, 0, 0, 0, 16777215, 0), 1'b1,
                    '{1'b0, '0, 1'b0}};
        rows[7] = '{make_hit(-524288, -524288, -524288, 524287, 524287, 524287,
                             -524288, -524288, -524288, 0, 16777215), 1'b0, '{1'b0, '0, 1'b0}};
        rows[8] = '{make_hit(524287, 524287, 524287, -524288, -524288, -524288,
                             524287, -524288, 524287, 16777215, 16777215), 1'b0,
                    '{1'b0, '0, 1'b0}};
        rows[9] = '{make_hit(0, 0, 0, 1000, 0, 0, 1000, 1000, 0, 0, 511000), 1'b0,
                    '{1'b0, '0, 1'b0}};
        rows[10] = '{make_hit(0, 0, -3, 0, 0, -1003, 0, 0, -3, 255000, 511000), 1'b0,
                     '{1'b0, '0, 1'b0}};
        rows[11] = '{make_hit(-1, 2, -3, 40, -50, 60, -700, 800, -900, 5000, 662000), 1'b0,
                     '{1'b0, '0, 1'b0}};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table at the reset tolerance.
        for (int i = 0; i < N_DIRECTED; i++)
            send_word(rows[i].h, rows[i].typed, rows[i].v);

        random_phase(140);
        write_tolerance('0);
        random_phase(100);
        write_tolerance({TOL_BITS{1'b1}});
        random_phase(100);
        write_tolerance(TOL_BITS'($urandom_range(1, 30000)));
        random_phase(100);
        write_tolerance(TOL_BITS'(1));
        random_phase(100);

        in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb_compton_scatter_angle_check: clean");
        else
            $display("tb_compton_scatter_angle_check: errors");
        $finish;
    end

    // Output side: random back-pressure, one long hold-off, and a calm window.
    initial
    begin
        logic held;
        held = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && words_seen >= 200)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            if (words_sent >= 300 && words_sent < 380)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99) >= 27);
        end
    end

    // Handshakes are sampled mid-cycle, where every input and output is settled.
    initial
    begin
        verdict_t exp_v;
        verdict_t got;
        fail_count = 0;
        words_seen = 0;
        any_fire = 1'b0;
        forever
        begin
            @(negedge clk);
            any_fire = 1'b0;
            if (rst_n && in_valid && in_ready)
            begin
                any_fire = 1'b1;
                if (cur_typed)
                    pending_q.push_back(cur_verdict);
                else
                    pending_q.push_back(compton_deposit(cur_hit, tol_copy));
            end
            if (rst_n && out_valid && out_ready)
            begin
                any_fire = 1'b1;
                words_seen++;
                got = '{acceptable, predicted_deposit, degenerate};
                if (pending_q.size() == 0)
                begin
                    $display("%0t: unexpected word acc=%0b pred=%0d deg=%0b",
                             $time, got.acc, got.pred, got.deg);
                    fail_count++;
                end
                else
                begin
                    exp_v = pending_q.pop_front();
                    if (got.acc !== exp_v.acc)
                    begin
                        $display("%0t: acceptable expected %0b actual %0b",
                                 $time, exp_v.acc, got.acc);
                        fail_count++;
                    end
                    if (got.pred !== exp_v.pred)
                    begin
                        $display("%0t: predicted_deposit expected %0d actual %0d",
                                 $time, exp_v.pred, got.pred);
                        fail_count++;
                    end
                    if (got.deg !== exp_v.deg)
                    begin
                        $display("%0t: degenerate expected %0b actual %0b",
                                 $time, exp_v.deg, got.deg);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles in which no word moves.
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if (any_fire)
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("tb_compton_scatter_angle_check: errors");
                $finish;
            end
        end
    end

endmodule

[sim.f]
+incdir+rtl
rtl/csac_pkg.sv
rtl/compton_scatter_angle_check.sv
tb/tb_compton_scatter_angle_check.sv
